FILE: design/dtc_pkg.sv
// Shared types, widths and register codes for the dense-to-COO slice encoder.
`default_nettype none
package dtc_pkg;

   // Field widths
   localparam int SIZE_W     = 16;
   localparam int ELEM_W     = 32;
   localparam int NUM_DIMS   = 4;
   localparam int MAX_DIMS   = 4;
   localparam int DIM_LIMIT  = (MAX_DIMS < NUM_DIMS) ? MAX_DIMS : NUM_DIMS;
   localparam int SPARSE_W   = 3;
   localparam int EW_W       = 2;
   localparam int LEN_W      = 48;
   localparam int MUL_A_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Default buffer depth
   localparam int SLICE_DEPTH_DEF = 64;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_DIM0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_DIM1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_DIM2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_DIM3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARSE_DIMS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEM_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOAT_MODE  = 3'd6;

   // Element width codes
   localparam logic [EW_W-1:0] EW_8  = 2'd0;
   localparam logic [EW_W-1:0] EW_16 = 2'd1;

   // Reset values
   localparam logic [SPARSE_W-1:0] SPARSE_DIMS_RST = 3'd4;
   localparam logic [EW_W-1:0]     ELEM_WIDTH_RST  = 2'd2;

   typedef logic [NUM_DIMS-1:0][SIZE_W-1:0] coord_vec_type;

   // Per-slice tag handed to the emitter at the end of a slice
   typedef struct packed {
      logic          start;
      logic          overflow;
      coord_vec_type coords;
   } slice_tag_type;

endpackage
`default_nettype wire

FILE: design/dtc_len_calc.sv
// Slice length unit: one shared multiplier stepped over the dense dimensions.
`default_nettype none
module dtc_len_calc (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire dtc_pkg::coord_vec_type               size_eff,
   input  wire logic [dtc_pkg::SPARSE_W-1:0]         num_sparse,
   output logic                                      busy,
   output logic [dtc_pkg::LEN_W-1:0]                 slice_len
);
   import dtc_pkg::*;

   logic [LEN_W-1:0]  acc_ff, acc_in;
   logic [1:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [1:0]        dim_idx;
   logic [SIZE_W-1:0] factor;
   logic [LEN_W-1:0]  prod;

   // Pick the factor for this step: innermost dimension first
   always_comb begin
      dim_idx = 2'd3 - step_ff;
      factor  = ({1'b0, dim_idx} >= num_sparse) ? size_eff[dim_idx] : SIZE_W'(1);
      prod    = acc_ff[MUL_A_W-1:0] * factor;
   end

   // Restart on any register write, otherwise advance one dimension a cycle
   always_comb begin
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in  = LEN_W'(1);
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = prod;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= LEN_W'(1);
         step_ff <= 2'd0;
         busy_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   assign busy      = busy_ff;
   assign slice_len = acc_ff;

endmodule
`default_nettype wire

FILE: design/dtc_slice_buf.sv
// Slice buffer: one write port, one read port with registered read data.
`default_nettype none
module dtc_slice_buf #(
   parameter int SLICE_DEPTH = dtc_pkg::SLICE_DEPTH_DEF,
   parameter int ADDR_W      = (SLICE_DEPTH > 1) ? $clog2(SLICE_DEPTH) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [dtc_pkg::ELEM_W-1:0]  wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic [dtc_pkg::ELEM_W-1:0]       rd_data
);
   import dtc_pkg::*;

   logic [ELEM_W-1:0] mem [SLICE_DEPTH];
   logic [ELEM_W-1:0] rd_data_ff;

   // Store incoming elements
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read into the data register
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: design/dtc_emit.sv
// Slice emitter: drains buffer into result register, one a cycle unless stalled.
`default_nettype none
module dtc_emit #(
   parameter int SLICE_DEPTH = dtc_pkg::SLICE_DEPTH_DEF,
   parameter int ADDR_W      = (SLICE_DEPTH > 1) ? $clog2(SLICE_DEPTH) : 1,
   parameter int CNT_W       = $clog2(SLICE_DEPTH + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dtc_pkg::slice_tag_type      tag,
   input  wire logic [CNT_W-1:0]            count,
   output logic                             busy,
   output logic                             rd_en,
   output logic [ADDR_W-1:0]                rd_addr,
   input  wire logic [dtc_pkg::ELEM_W-1:0]  rd_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output dtc_pkg::coord_vec_type           rsp_coords,
   output logic [dtc_pkg::ELEM_W-1:0]       rsp_value,
   output logic                             rsp_last,
   output logic                             rsp_overflow
);
   import dtc_pkg::*;

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             ovf_ff;
   coord_vec_type    coords_ff;
   logic             rd_valid_ff, rd_valid_in;
   logic             rd_last_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   coord_vec_type    rsp_coords_ff;
   logic [ELEM_W-1:0] rsp_value_ff;
   logic             rsp_last_ff;
   logic             rsp_ovf_ff;
   logic             load;
   logic             issue;
   logic             all_issued;

   // Move read data into the result register when it is free
   always_comb begin
      load       = rd_valid_ff && (!rsp_valid_ff || rsp_ready);
      all_issued = (idx_ff == cnt_ff);
      issue      = busy_ff && !all_issued && (!rd_valid_ff || load);
   end

   // Sequence the drain
   always_comb begin
      busy_in     = busy_ff;
      idx_in      = idx_ff;
      rd_valid_in = rd_valid_ff;
      if (tag.start) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else begin
         if (issue) begin
            idx_in = idx_ff + CNT_W'(1);
         end
         if (busy_ff && all_issued && (!rd_valid_ff || load)) begin
            busy_in = 1'b0;
         end
      end
      if (issue) begin
         rd_valid_in = 1'b1;
      end else if (load) begin
         rd_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the slice tag for the whole drain
   always_ff @(posedge clock) begin
      if (tag.start) begin
         cnt_ff    <= count;
         ovf_ff    <= tag.overflow;
         coords_ff <= tag.coords;
      end
      if (issue) begin
         rd_last_ff <= ((idx_ff + CNT_W'(1)) == cnt_ff);
      end
      if (load) begin
         rsp_coords_ff <= coords_ff;
         rsp_value_ff  <= rd_data;
         rsp_last_ff   <= rd_last_ff;
         rsp_ovf_ff    <= ovf_ff;
      end
   end

   assign busy         = busy_ff;
   assign rd_en        = issue;
   assign rd_addr      = idx_ff[ADDR_W-1:0];
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_coords   = rsp_coords_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

FILE: design/dense_to_coo_sparse_encoder_core.sv
// Dense-to-COO slice encoder top level.
//
// Dense elements arrive on the req_ channel, one per transaction, in row-major
// order with dimension 3 fastest. The leading sparse dimensions select a slice;
// the first SLICE_DEPTH elements of a slice are stored in a buffer. On the last
// element of a slice that holds any nonzero element, the stored elements leave
// on the rsp_ channel, each tagged with the slice's sparse coordinates.
// Input: one element per cycle while a slice fills, outside csr_ writes and
// length updates. After a slice with a nonzero element the block drains
// min(length, SLICE_DEPTH) results at one a cycle while the receiver accepts;
// the first result passes the emitter's busy, read data and result registers,
// and req_ready returns once the last read is loaded into the result register.
// The buffer read port sets the drain rate. A write on the csr_ port restarts
// the slice length unit, a shared 32x16 multiplier stepped over the three
// inner dimensions: req_ready is low in that cycle and while the unit is busy.
// Reset clears the slice state and coordinates and loads the register reset
// values; no buffer clearing pass is needed. When the receiver stalls, the
// result register holds and the drain pauses.
`default_nettype none
module dense_to_coo_sparse_encoder_core #(
   parameter int SLICE_DEPTH = dtc_pkg::SLICE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [dtc_pkg::ELEM_W-1:0]       req_elem_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [dtc_pkg::SIZE_W-1:0]            rsp_coord0,
   output logic [dtc_pkg::SIZE_W-1:0]            rsp_coord1,
   output logic [dtc_pkg::SIZE_W-1:0]            rsp_coord2,
   output logic [dtc_pkg::SIZE_W-1:0]            rsp_coord3,
   output logic [dtc_pkg::ELEM_W-1:0]            rsp_out_value,
   output logic                                  rsp_slice_last,
   output logic                                  rsp_slice_overflow,
   input  wire logic                             csr_wr_en,
   input  wire logic [dtc_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  wire logic [dtc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dtc_pkg::*;

   localparam int ADDR_W = (SLICE_DEPTH > 1) ? $clog2(SLICE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(SLICE_DEPTH + 1);

   // Configuration registers
   coord_vec_type       size_ff;
   logic [SPARSE_W-1:0] sparse_dims_ff;
   logic [EW_W-1:0]     elem_width_ff;
   logic                float_mode_ff;

   // Slice state
   logic [LEN_W-1:0]    pos_ff, pos_in;
   logic                any_nz_ff, any_nz_in;
   logic                ovf_ff, ovf_in;
   coord_vec_type       coord_ff, coord_in;

   coord_vec_type       size_eff;
   logic [SPARSE_W-1:0] num_sparse;
   logic                calc_busy;
   logic [LEN_W-1:0]    slice_len;
   logic                emit_busy;
   logic                accept;
   logic [ELEM_W-1:0]   mask, top_bit, masked, test_val;
   logic [LEN_W-1:0]    pos_next;
   logic                in_depth;
   logic                slice_end;
   logic                any_nz_next;
   logic                ovf_next;
   logic                carry;
   logic [SIZE_W:0]     digit_inc;
   slice_tag_type       tag;
   logic [CNT_W-1:0]    emit_count;
   coord_vec_type       rsp_coords;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ELEM_W-1:0]   rd_data;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIMS; i++) begin
            size_ff[i] <= SIZE_W'(1);
         end
         sparse_dims_ff <= SPARSE_DIMS_RST;
         elem_width_ff  <= ELEM_WIDTH_RST;
         float_mode_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_SIZE_DIM0:   size_ff[0]     <= csr_wdata;
            CSR_SIZE_DIM1:   size_ff[1]     <= csr_wdata;
            CSR_SIZE_DIM2:   size_ff[2]     <= csr_wdata;
            CSR_SIZE_DIM3:   size_ff[3]     <= csr_wdata;
            CSR_SPARSE_DIMS: sparse_dims_ff <= csr_wdata[SPARSE_W-1:0];
            CSR_ELEM_WIDTH:  elem_width_ff  <= csr_wdata[EW_W-1:0];
            CSR_FLOAT_MODE:  float_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective extents and sparse dimension count
   always_comb begin
      for (int i = 0; i < NUM_DIMS; i++) begin
         if (i >= DIM_LIMIT || size_ff[i] == '0) begin
            size_eff[i] = SIZE_W'(1);
         end else begin
            size_eff[i] = size_ff[i];
         end
      end
      if (sparse_dims_ff == '0) begin
         num_sparse = SPARSE_W'(1);
      end else if (sparse_dims_ff > SPARSE_W'(DIM_LIMIT)) begin
         num_sparse = SPARSE_W'(DIM_LIMIT);
      end else begin
         num_sparse = sparse_dims_ff;
      end
   end

   dtc_len_calc u_len_calc (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_wr_en),
      .size_eff   (size_eff),
      .num_sparse (num_sparse),
      .busy       (calc_busy),
      .slice_len  (slice_len)
   );

   assign req_ready = !calc_busy && !emit_busy && !csr_wr_en;
   assign accept    = req_valid && req_ready;

   // Mask the element and test it
   always_comb begin
      case (elem_width_ff)
         EW_8: begin
            mask    = ELEM_W'(32'h0000_00FF);
            top_bit = ELEM_W'(32'h0000_0080);
         end
         EW_16: begin
            mask    = ELEM_W'(32'h0000_FFFF);
            top_bit = ELEM_W'(32'h0000_8000);
         end
         default: begin
            mask    = ELEM_W'(32'hFFFF_FFFF);
            top_bit = ELEM_W'(32'h8000_0000);
         end
      endcase
      masked      = req_elem_value & mask;
      test_val    = float_mode_ff ? (masked & ~top_bit) : masked;
      any_nz_next = any_nz_ff || (test_val != '0);
      in_depth    = (pos_ff < LEN_W'(SLICE_DEPTH));
      ovf_next    = ovf_ff || !in_depth;
      pos_next    = pos_ff + LEN_W'(1);
      slice_end   = (pos_next >= slice_len);
      if (pos_next < LEN_W'(SLICE_DEPTH)) begin
         emit_count = pos_next[CNT_W-1:0];
      end else begin
         emit_count = CNT_W'(SLICE_DEPTH);
      end
   end

   // Advance the odometer, last sparse dimension fastest
   always_comb begin
      coord_in  = coord_ff;
      carry     = 1'b1;
      digit_inc = '0;
      for (int d = NUM_DIMS - 1; d >= 0; d--) begin
         digit_inc = {1'b0, coord_ff[d]} + (SIZE_W + 1)'(1);
         if ((SPARSE_W'(d) < num_sparse) && carry) begin
            if (digit_inc >= {1'b0, size_eff[d]}) begin
               coord_in[d] = '0;
            end else begin
               coord_in[d] = digit_inc[SIZE_W-1:0];
               carry       = 1'b0;
            end
         end
      end
   end

   // Build the slice tag for the emitter
   always_comb begin
      tag.start    = accept && slice_end && any_nz_next;
      tag.overflow = ovf_next;
      for (int d = 0; d < NUM_DIMS; d++) begin
         tag.coords[d] = (SPARSE_W'(d) < num_sparse) ? coord_ff[d] : '0;
      end
   end

   // Update slice state per accepted transaction
   always_comb begin
      pos_in    = pos_ff;
      any_nz_in = any_nz_ff;
      ovf_in    = ovf_ff;
      if (accept) begin
         if (slice_end) begin
            pos_in    = '0;
            any_nz_in = 1'b0;
            ovf_in    = 1'b0;
         end else begin
            pos_in    = pos_next;
            any_nz_in = any_nz_next;
            ovf_in    = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         any_nz_ff <= 1'b0;
         ovf_ff    <= 1'b0;
         coord_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         any_nz_ff <= any_nz_in;
         ovf_ff    <= ovf_in;
         if (accept && slice_end) begin
            coord_ff <= coord_in;
         end
      end
   end

   dtc_slice_buf #(
      .SLICE_DEPTH (SLICE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_slice_buf (
      .clock   (clock),
      .wr_en   (accept && in_depth),
      .wr_addr (pos_ff[ADDR_W-1:0]),
      .wr_data (masked),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dtc_emit #(
      .SLICE_DEPTH (SLICE_DEPTH),
      .ADDR_W      (ADDR_W),
      .CNT_W       (CNT_W)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .tag          (tag),
      .count        (emit_count),
      .busy         (emit_busy),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_coords   (rsp_coords),
      .rsp_value    (rsp_out_value),
      .rsp_last     (rsp_slice_last),
      .rsp_overflow (rsp_slice_overflow)
   );

   assign rsp_coord0 = rsp_coords[0];
   assign rsp_coord1 = rsp_coords[1];
   assign rsp_coord2 = rsp_coords[2];
   assign rsp_coord3 = rsp_coords[3];

endmodule
`default_nettype wire
